FILE: hw/rtl/tsa_pkg.sv
// ----------------------------------------------------------------------------
// tsa_pkg
// Shared constants, types and helper functions of the typed slot allocator.
// ----------------------------------------------------------------------------
package tsa_pkg;

	localparam int SLOT_COUNT     = 1024;
	localparam int TYPE_COUNT     = 6;
	localparam int RESERVED_SLOTS = 256;

	localparam int VB_TYPE      = 2;
	localparam int DEFAULT_HINT = 1;

	localparam int TYPE_W    = 3;
	localparam int SLOT_IN_W = 10;
	localparam int STATUS_W  = 2;

	localparam int WORD_BITS  = 32;
	localparam int WORD_W     = $clog2(WORD_BITS);
	localparam int SLOT_W     = $clog2(SLOT_COUNT);
	localparam int WIDX_W     = SLOT_W - WORD_W;
	localparam int ADDR_W     = TYPE_W + WIDX_W;
	localparam int HINT_W     = $clog2(SLOT_COUNT + 1);
	localparam int TYPE_SLOTS = 1 << TYPE_W;

	localparam int RESERVED_CLAMP = (RESERVED_SLOTS > SLOT_COUNT) ? SLOT_COUNT : RESERVED_SLOTS;
	localparam bit VB_PRESENT     = (TYPE_COUNT > VB_TYPE);
	localparam int LAST_WORD_I    = (SLOT_COUNT - 1) / WORD_BITS;
	localparam int LAST_FILL      = SLOT_COUNT - LAST_WORD_I * WORD_BITS;

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [ADDR_W-1:0]    addr_t;
	typedef logic [SLOT_W-1:0]    slot_t;
	typedef logic [HINT_W-1:0]    hint_t;
	typedef logic [WIDX_W-1:0]    widx_t;
	typedef logic [WORD_W-1:0]    woff_t;
	typedef logic [TYPE_W-1:0]    type_t;
	typedef logic [SLOT_IN_W-1:0] slot_io_t;

	localparam widx_t LAST_WORD = widx_t'(LAST_WORD_I);
	localparam word_t LAST_MASK = word_t'((64'd1 << LAST_FILL) - 64'd1);
	localparam hint_t HINT_END  = hint_t'(SLOT_COUNT);

	typedef enum logic {
		OP_ALLOC,
		OP_RELEASE
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK,
		ST_FULL,
		ST_RANGE,
		ST_FREE
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_RELCHK,
		S_RESP
	} eng_state_t;

	typedef struct packed {
		logic  re;
		logic  we;
		addr_t addr;
		word_t wdata;
	} mem_req_t;

	typedef struct packed {
		logic     valid;
		slot_io_t slot;
		status_t  status;
	} res_t;

	typedef struct packed {
		logic  found;
		woff_t idx;
	} find_t;

	function automatic hint_t hint_init(int t);
		if (VB_PRESENT && t == VB_TYPE)
			return hint_t'(RESERVED_CLAMP);
		return hint_t'(DEFAULT_HINT);
	endfunction

	function automatic word_t row_init(addr_t a);
		word_t r;
		int    w;
		r = '0;
		w = int'(a[WIDX_W-1:0]);
		if (VB_PRESENT && a[ADDR_W-1:WIDX_W] == type_t'(VB_TYPE)) begin
			for (int b = 0; b < WORD_BITS; b++)
				r[b] = ((w * WORD_BITS + b) < RESERVED_CLAMP);
		end
		return r;
	endfunction

	function automatic find_t first_set(word_t v);
		find_t f;
		f.found = |v;
		f.idx   = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (v[i])
				f.idx = woff_t'(i);
		end
		return f;
	endfunction

endpackage

FILE: hw/rtl/tsa_occ_store.sv
// ----------------------------------------------------------------------------
// tsa_occ_store
// Occupancy memory, one row of slot bits per type and word, with a
// clearing pass after reset that loads the reserved pattern.
// ----------------------------------------------------------------------------
module tsa_occ_store (
	input  logic              clk,
	input  logic              arst_n,
	input  tsa_pkg::mem_req_t req,
	output tsa_pkg::word_t    rdata,
	output logic              clr_busy
);
	import tsa_pkg::*;

	word_t mem [2**ADDR_W];
	addr_t clr_q;
	logic  busy_q;
	word_t rdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			clr_q <= clr_q + addr_t'(1);
			if (clr_q == '1)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q)
			mem[clr_q] <= row_init(clr_q);
		else if (req.we)
			mem[req.addr] <= req.wdata;
	end

	always_ff @(posedge clk) begin
		if (req.re)
			rdata_q <= mem[req.addr];
	end

	assign rdata    = rdata_q;
	assign clr_busy = busy_q;

endmodule

FILE: hw/rtl/tsa_engine.sv
// ----------------------------------------------------------------------------
// tsa_engine
// Request sequencer: first-free hints, word-by-word scan for allocate,
// read-check-write for release.
// ----------------------------------------------------------------------------
module tsa_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  tsa_pkg::op_t      op_in,
	input  tsa_pkg::type_t    type_in,
	input  tsa_pkg::slot_io_t slot_in,
	input  logic              clr_busy,
	output tsa_pkg::mem_req_t req,
	input  tsa_pkg::word_t    rdata,
	output tsa_pkg::res_t     res,
	input  logic              res_ready
);
	import tsa_pkg::*;

	eng_state_t state_q, state_d;
	hint_t      hint_q [TYPE_SLOTS];
	type_t      type_q;
	slot_t      slot_q;
	widx_t      word_q, word_d;
	woff_t      lo_q, lo_d;
	slot_io_t   res_slot_q, res_slot_d;
	status_t    res_status_q, res_status_d;
	logic       res_load;
	logic       hint_we;
	hint_t      hint_d;
	logic       in_fire;
	logic       type_ok_in, slot_ok_in;
	slot_t      slot_ext;
	hint_t      hint_in, hint_cur;
	word_t      free_vec;
	find_t      fnd;

	assign in_ready   = (state_q == S_IDLE) && !clr_busy;
	assign in_fire    = in_valid && in_ready;
	assign type_ok_in = (32'(type_in) < 32'(TYPE_COUNT));
	assign slot_ok_in = (32'(slot_in) < 32'(SLOT_COUNT));
	assign slot_ext   = slot_t'(slot_in);
	assign hint_in    = hint_q[type_in];
	assign hint_cur   = hint_q[type_q];
	assign free_vec   = ~rdata & (word_t'('1) << lo_q)
		& ((word_q == LAST_WORD) ? LAST_MASK : word_t'('1));
	assign fnd        = first_set(free_vec);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d      = state_q;
		req          = '0;
		word_d       = word_q;
		lo_d         = lo_q;
		res_load     = 1'b0;
		res_slot_d   = '0;
		res_status_d = ST_OK;
		hint_we      = 1'b0;
		hint_d       = hint_cur;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					if (op_in == OP_ALLOC) begin
						if (!type_ok_in || hint_in >= HINT_END) begin
							res_load     = 1'b1;
							res_status_d = ST_FULL;
							state_d      = S_RESP;
						end else begin
							req.re   = 1'b1;
							req.addr = {type_in, hint_in[SLOT_W-1:WORD_W]};
							word_d   = hint_in[SLOT_W-1:WORD_W];
							lo_d     = hint_in[WORD_W-1:0];
							state_d  = S_SCAN;
						end
					end else begin
						if (!type_ok_in) begin
							res_load     = 1'b1;
							res_slot_d   = slot_in;
							res_status_d = ST_FREE;
							state_d      = S_RESP;
						end else if (!slot_ok_in) begin
							res_load     = 1'b1;
							res_slot_d   = slot_in;
							res_status_d = ST_RANGE;
							state_d      = S_RESP;
						end else begin
							req.re   = 1'b1;
							req.addr = {type_in, slot_ext[SLOT_W-1:WORD_W]};
							word_d   = slot_ext[SLOT_W-1:WORD_W];
							lo_d     = slot_ext[WORD_W-1:0];
							state_d  = S_RELCHK;
						end
					end
				end
			end
			S_SCAN: begin
				if (fnd.found) begin
					req.we       = 1'b1;
					req.addr     = {type_q, word_q};
					req.wdata    = rdata | (word_t'(1) << fnd.idx);
					hint_we      = 1'b1;
					hint_d       = hint_t'({word_q, fnd.idx}) + hint_t'(1);
					res_load     = 1'b1;
					res_slot_d   = slot_io_t'({word_q, fnd.idx});
					res_status_d = ST_OK;
					state_d      = S_RESP;
				end else if (word_q == LAST_WORD) begin
					res_load     = 1'b1;
					res_status_d = ST_FULL;
					state_d      = S_RESP;
				end else begin
					req.re   = 1'b1;
					req.addr = {type_q, word_q + widx_t'(1)};
					word_d   = word_q + widx_t'(1);
					lo_d     = '0;
				end
			end
			S_RELCHK: begin
				res_load   = 1'b1;
				res_slot_d = slot_io_t'(slot_q);
				state_d    = S_RESP;
				if (!rdata[lo_q]) begin
					res_status_d = ST_FREE;
				end else begin
					req.we       = 1'b1;
					req.addr     = {type_q, word_q};
					req.wdata    = rdata & ~(word_t'(1) << lo_q);
					res_status_d = ST_OK;
					if (hint_t'(slot_q) < hint_cur) begin
						hint_we = 1'b1;
						hint_d  = hint_t'(slot_q);
					end
				end
			end
			S_RESP: begin
				if (res_ready)
					state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TYPE_SLOTS; i++)
				hint_q[i] <= hint_init(i);
		end else if (hint_we) begin
			hint_q[type_q] <= hint_d;
		end
	end

	always_ff @(posedge clk) begin
		word_q <= word_d;
		lo_q   <= lo_d;
		if (in_fire) begin
			type_q <= type_in;
			slot_q <= slot_ext;
		end
		if (res_load) begin
			res_slot_q   <= res_slot_d;
			res_status_q <= res_status_d;
		end
	end

	assign res.valid  = (state_q == S_RESP);
	assign res.slot   = res_slot_q;
	assign res.status = res_status_q;

endmodule

FILE: hw/rtl/typed_slot_allocator.sv
// ----------------------------------------------------------------------------
// typed_slot_allocator
// Per-type slot allocator over a shared occupancy table, first-free hints,
// result held in an output register.
// ----------------------------------------------------------------------------
// allocate: scans words of 32 slots from the type's hint (1 to 32 words),
//   one word per cycle
// release: read, check, write
// rejected requests are answered without a memory read; one request in flight at a time
// reset: hints load at once; occupancy memory is rewritten by a clearing pass over all
//   256 rows (one row per cycle), s_tready stays low until it is done
module typed_slot_allocator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // type_index [2:0], slot_to_release [12:3]
	input  logic [0:0]  s_tuser,   // operation [0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // slot_number [9:0]
	output logic [1:0]  m_tuser    // status [1:0]
);
	import tsa_pkg::*;

	mem_req_t req;
	word_t    rdata;
	logic     clr_busy;
	res_t     res;
	logic     res_ready;
	logic     out_valid_q;
	slot_io_t out_slot_q;
	status_t  out_status_q;

	tsa_occ_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rdata    (rdata),
		.clr_busy (clr_busy)
	);

	tsa_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.op_in     (op_t'(s_tuser[0])),
		.type_in   (s_tdata[2:0]),
		.slot_in   (s_tdata[12:3]),
		.clr_busy  (clr_busy),
		.req       (req),
		.rdata     (rdata),
		.res       (res),
		.res_ready (res_ready)
	);

	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (res.valid && res_ready)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (res.valid && res_ready) begin
			out_slot_q   <= res.slot;
			out_status_q <= res.status;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, out_slot_q};
	assign m_tuser  = out_status_q;

	a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy |-> !s_tready)
		else $error("request accepted during clearing pass");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second request accepted while one is in flight");

	a_full_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == ST_FULL) |-> (m_tdata[9:0] == 10'd0))
		else $error("table full result carries a nonzero slot");

	a_range_beyond_table: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == ST_RANGE) |-> (32'(m_tdata[9:0]) >= 32'(SLOT_COUNT)))
		else $error("out of range status for a slot inside the table");

endmodule

FILE: tb/sv/typed_slot_allocator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// typed_slot_allocator_tb
// Self-checking bench for the typed slot allocator. Allocate and release
// transactions go in over the request stream. A scoreboard keeps its own
// occupancy table and first-free hints, predicts each response and compares
// it with the response stream. Random gaps and stalls are applied on both
// sides. The vertex-buffer type is run until the table is full.
// ----------------------------------------------------------------------------
module typed_slot_allocator_tb;
	import tsa_pkg::*;

	class slot_scoreboard;
		bit [TYPE_COUNT-1:0] occ [SLOT_COUNT];
		int                  hint [TYPE_COUNT];
		slot_io_t            slot_q [$];
		status_t             status_q [$];
		int                  fails;
		int                  n_checked;
		int                  n_grant;
		int                  n_full;
		int                  n_freed;
		int                  n_refused;

		function new();
			int rsv;
			rsv = (RESERVED_SLOTS > SLOT_COUNT) ? SLOT_COUNT : RESERVED_SLOTS;
			for (int i = 0; i < SLOT_COUNT; i++)
				occ[i] = '0;
			for (int t = 0; t < TYPE_COUNT; t++)
				hint[t] = DEFAULT_HINT;
			if (TYPE_COUNT > VB_TYPE) begin
				for (int i = 0; i < rsv; i++)
					occ[i][VB_TYPE] = 1'b1;
				hint[VB_TYPE] = rsv;
			end
			fails = 0;
			n_checked = 0;
			n_grant = 0;
			n_full = 0;
			n_freed = 0;
			n_refused = 0;
		endfunction

		task report_mismatch(string msg);
			$display("mismatch at %0t: %s", $time, msg);
			fails++;
		endtask

		function int pending();
			return slot_q.size();
		endfunction

		function bit is_full(int t);
			for (int i = hint[t]; i < SLOT_COUNT; i++)
				if (!occ[i][t])
					return 1'b0;
			return 1'b1;
		endfunction

		// random slot currently held by type t, -1 if none
		function int pick_held(int t);
			int held [$];
			for (int i = 0; i < SLOT_COUNT; i++)
				if (occ[i][t])
					held.push_back(i);
			if (held.size() == 0)
				return -1;
			return held[$urandom_range(0, held.size() - 1)];
		endfunction

		function void note_request(op_t op, logic [2:0] ty, slot_io_t sl);
			int       t;
			int       s;
			slot_io_t res_slot;
			status_t  res_st;
			t = int'(ty);
			s = int'(sl);
			res_slot = sl;
			if (op == OP_ALLOC) begin
				res_slot = '0;
				res_st = ST_FULL;
				if (t < TYPE_COUNT) begin
					for (int i = hint[t]; i < SLOT_COUNT; i++) begin
						if (!occ[i][t]) begin
							occ[i][t] = 1'b1;
							hint[t] = i + 1;
							res_slot = slot_io_t'(i);
							res_st = ST_OK;
							break;
						end
					end
				end
				if (res_st == ST_OK)
					n_grant++;
				else
					n_full++;
			end else begin
				if (t >= TYPE_COUNT)
					res_st = ST_FREE;
				else if (s >= SLOT_COUNT)
					res_st = ST_RANGE;
				else if (!occ[s][t])
					res_st = ST_FREE;
				else begin
					occ[s][t] = 1'b0;
					if (s < hint[t])
						hint[t] = s;
					res_st = ST_OK;
				end
				if (res_st == ST_OK)
					n_freed++;
				else
					n_refused++;
			end
			slot_q.push_back(res_slot);
			status_q.push_back(res_st);
		endfunction

		task check_result(slot_io_t sl, status_t st);
			slot_io_t want_slot;
			status_t  want_st;
			if (slot_q.size() == 0) begin
				report_mismatch($sformatf("unexpected response slot %0d status %0d", sl, st));
				return;
			end
			want_slot = slot_q.pop_front();
			want_st = status_q.pop_front();
			n_checked++;
			if (sl !== want_slot)
				report_mismatch($sformatf("slot_number %0d, predicted %0d", sl, want_slot));
			if (st !== want_st)
				report_mismatch($sformatf("status %0d, predicted %0d", st, want_st));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic [0:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic [1:0]  m_tuser;

	slot_scoreboard sb = new();
	int             n_sent;
	bit             tx_idle_en;
	bit             rx_stall_en;
	int             rx_hold;

	typed_slot_allocator u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	initial begin
		#2000000;
		$display("TB_ERROR");
		$finish;
	end

	// response side back-pressure
	always @(negedge clk) begin
		int r;
		if (rx_hold > 0) begin
			m_tready = 1'b0;
			rx_hold--;
		end else begin
			r = $urandom_range(0, 99);
			if (!rx_stall_en || r < 65)
				m_tready = 1'b1;
			else if (r < 95)
				m_tready = 1'b0;
			else begin
				m_tready = 1'b0;
				rx_hold = $urandom_range(8, 40);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(slot_io_t'(m_tdata[9:0]), status_t'(m_tuser));
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_req(input op_t op, input int ty, input int sl);
		int          g;
		logic [2:0]  ty_b;
		slot_io_t    sl_b;
		ty_b = ty[2:0];
		sl_b = sl[9:0];
		tx_idle_en = (n_sent % 300) < 200;
		rx_stall_en = ((n_sent / 150) % 3) != 2;
		g = tx_idle_en ? pick_gap() : 0;
		if (g > 0) begin
			s_tvalid = 1'b0;
			repeat (g) @(negedge clk);
		end
		s_tuser = op;
		s_tdata = {3'b000, sl_b, ty_b};
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		sb.note_request(op, ty_b, sl_b);
		n_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid = 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	task automatic send_noise();
		send_req(op_t'($urandom_range(0, 1)), $urandom_range(0, 7), $urandom_range(0, 1023));
	endtask

	initial begin
		int r;
		int t;
		int h;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		n_sent = 0;
		tx_idle_en = 1'b1;
		rx_stall_en = 1'b1;
		rx_hold = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed
		send_req(OP_ALLOC, 0, 0);
		send_req(OP_ALLOC, 5, 1023);
		send_req(OP_ALLOC, VB_TYPE, 0);
		send_req(OP_ALLOC, 6, 0);
		send_req(OP_ALLOC, 7, 1023);
		send_req(OP_RELEASE, 7, 1023);
		send_req(OP_RELEASE, 6, 1);
		send_req(OP_RELEASE, 0, 1);
		send_req(OP_RELEASE, 0, 1);
		send_req(OP_RELEASE, 0, 0);
		send_req(OP_RELEASE, VB_TYPE, 0);
		send_req(OP_ALLOC, VB_TYPE, 0);
		send_req(OP_RELEASE, VB_TYPE, 255);
		send_req(OP_ALLOC, VB_TYPE, 0);
		send_req(OP_RELEASE, 1, 1023);
		send_req(OP_ALLOC, 1, 0);
		send_req(OP_ALLOC, 3, 0);
		send_req(OP_ALLOC, 4, 0);
		send_req(OP_ALLOC, 3, 0);
		send_req(OP_RELEASE, 3, 1);
		send_req(OP_ALLOC, 3, 0);
		send_req(OP_RELEASE, VB_TYPE, 512);
		drain();

		// fill the vertex-buffer type until the table is full
		while (!sb.is_full(VB_TYPE)) begin
			if ($urandom_range(0, 99) < 88)
				send_req(OP_ALLOC, VB_TYPE, $urandom_range(0, 1023));
			else
				send_noise();
		end
		repeat (4) send_req(OP_ALLOC, VB_TYPE, $urandom_range(0, 1023));
		send_req(OP_RELEASE, VB_TYPE, 1023);
		send_req(OP_ALLOC, VB_TYPE, 0);
		send_req(OP_ALLOC, VB_TYPE, 0);
		drain();

		// mixed allocate and release traffic over all types
		while (n_sent < 1100) begin
			r = $urandom_range(0, 99);
			t = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 7) : $urandom_range(0, 5);
			if (r < 45)
				send_req(OP_ALLOC, t, $urandom_range(0, 1023));
			else if (r < 82 && t < TYPE_COUNT) begin
				h = sb.pick_held(t);
				if (h < 0)
					send_req(OP_ALLOC, t, 0);
				else
					send_req(OP_RELEASE, t, h);
			end else
				send_noise();
		end
		drain();
		repeat (40) @(posedge clk);

		$display("sent %0d transactions, checked %0d responses", n_sent, sb.n_checked);
		$display("grants %0d, full %0d, releases %0d, refused releases %0d",
			sb.n_grant, sb.n_full, sb.n_freed, sb.n_refused);
		if (sb.fails == 0 && sb.pending() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
